FILE: sv/drcf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the delimited record column filter.
// No dependencies; the interfaces, input register, line core and top level refer to this package.
package drcf_pkg;

    localparam int VAL_W      = 32;
    localparam int COLREG_W   = 6;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP = 2'd2;

    // Compare operators; any other code never keeps
    localparam logic [OP_W-1:0] OP_GT = 3'd0;
    localparam logic [OP_W-1:0] OP_GE = 3'd1;
    localparam logic [OP_W-1:0] OP_LT = 3'd2;
    localparam logic [OP_W-1:0] OP_LE = 3'd3;
    localparam logic [OP_W-1:0] OP_EQ = 3'd4;
    localparam logic [OP_W-1:0] OP_NE = 3'd5;

    // Characters
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Saturation bound of the column magnitude
    localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } item_t;

    typedef struct packed {
        logic [COLREG_W-1:0] column_a;
        logic [COLREG_W-1:0] column_b;
        logic [OP_W-1:0]     compare_op;
    } cfg_t;

endpackage

FILE: sv/drcf_interfaces.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: byte requests in, line results out, register writes.
// Depends on drcf_pkg for field widths.
interface drcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       flush;

    modport source (output valid, data_byte, flush, input ready);
    modport sink   (input valid, data_byte, flush, output ready);
endinterface

interface drcf_out_if #(
    parameter int LEN_W = 13
);
    logic             valid;
    logic             ready;
    logic             keep_line;
    logic [LEN_W-1:0] line_length;

    modport source (output valid, keep_line, line_length, input ready);
    modport sink   (input valid, keep_line, line_length, output ready);
endinterface

interface drcf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [drcf_pkg::CFG_IDX_W-1:0]      index;
    logic [drcf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/drcf_in_stage.sv
`timescale 1ns / 1ps
// Input register: holds one byte request until the line core takes it.
// Depends on drcf_pkg.
module drcf_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  drcf_pkg::item_t in_item,
    input  logic            advance,
    output logic            held_valid,
    output drcf_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    drcf_pkg::item_t item_reg;

    // Take a new request when empty or when the held one moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: sv/drcf_line_core.sv
`timescale 1ns / 1ps
// Per-byte column parser, capture of the two compared columns and line decision.
// Depends on drcf_pkg.
module drcf_line_core #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_LINE    = 4096,
    localparam int LEN_W      = $clog2(MAX_LINE + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  drcf_pkg::item_t  item,
    input  drcf_pkg::cfg_t   cfg,
    output logic             emit,
    output logic             keep_line,
    output logic [LEN_W-1:0] line_length
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W = (COL_W + 1 > drcf_pkg::COLREG_W) ? COL_W + 1 : drcf_pkg::COLREG_W;
    localparam int ACC_W = drcf_pkg::VAL_W + 4;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [COL_W-1:0]                 idx_reg, idx_next;
    logic [1:0]                       phase_reg, phase_next;
    logic                             neg_reg, neg_next;
    logic [drcf_pkg::VAL_W-1:0]       acc_reg, acc_next;
    logic signed [drcf_pkg::VAL_W-1:0] cap_a_reg, cap_a_next;
    logic signed [drcf_pkg::VAL_W-1:0] cap_b_reg, cap_b_next;
    logic [LEN_W-1:0]                 len_reg, len_next;

    logic [7:0]                       c;
    logic                             is_nl, is_colon, is_space, is_sign, is_digit;
    logic [LEN_W-1:0]                 len_inc;
    logic [ACC_W-1:0]                 acc_mul;
    logic [drcf_pkg::VAL_W-1:0]       acc_dig;
    logic signed [drcf_pkg::VAL_W-1:0] col_val;
    logic                             idx_ok, hit_a, hit_b;
    logic signed [drcf_pkg::VAL_W-1:0] fin_a, fin_b;

    always_comb
    begin
        c        = item.data_byte;
        is_nl    = !item.flush && (c == drcf_pkg::CHAR_NL);
        is_colon = !item.flush && (c == drcf_pkg::CHAR_COLON);
        is_space = (c == drcf_pkg::CHAR_SPACE) ||
                   ((c >= drcf_pkg::CHAR_TAB) && (c <= drcf_pkg::CHAR_CR));
        is_sign  = (c == drcf_pkg::CHAR_PLUS) || (c == drcf_pkg::CHAR_MINUS);
        is_digit = (c >= drcf_pkg::CHAR_ZERO) && (c <= drcf_pkg::CHAR_NINE);

        len_inc = (len_reg < LEN_W'(MAX_LINE)) ? len_reg + LEN_W'(1) : len_reg;

        // times ten plus digit, saturating at the magnitude limit
        acc_mul = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1) + ACC_W'(c - drcf_pkg::CHAR_ZERO);
        acc_dig = (acc_mul > ACC_W'(drcf_pkg::MAG_LIMIT)) ? drcf_pkg::MAG_LIMIT
                                                         : acc_mul[drcf_pkg::VAL_W-1:0];

        // negating the limit lands on the most negative value by itself
        if (neg_reg)
            col_val = -$signed(acc_reg);
        else if (acc_reg[drcf_pkg::VAL_W-1])
            col_val = $signed(drcf_pkg::VAL_MAX);
        else
            col_val = $signed(acc_reg);

        idx_ok = idx_reg < COL_W'(MAX_COLUMNS);
        hit_a  = idx_ok && (CMP_W'(idx_reg) + CMP_W'(1) == CMP_W'(cfg.column_a));
        hit_b  = idx_ok && (CMP_W'(idx_reg) + CMP_W'(1) == CMP_W'(cfg.column_b));
        fin_a  = hit_a ? col_val : cap_a_reg;
        fin_b  = hit_b ? col_val : cap_b_reg;

        emit        = item.flush ? (len_reg != '0) : is_nl;
        line_length = item.flush ? len_reg : len_inc;

        case (cfg.compare_op)
            drcf_pkg::OP_GT: keep_line = fin_a >  fin_b;
            drcf_pkg::OP_GE: keep_line = fin_a >= fin_b;
            drcf_pkg::OP_LT: keep_line = fin_a <  fin_b;
            drcf_pkg::OP_LE: keep_line = fin_a <= fin_b;
            drcf_pkg::OP_EQ: keep_line = fin_a == fin_b;
            drcf_pkg::OP_NE: keep_line = fin_a != fin_b;
            default:         keep_line = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cap_a_next = cap_a_reg;
        cap_b_next = cap_b_reg;
        len_next   = len_reg;

        if (step)
        begin
            if (emit)
            begin
                // start a fresh line
                idx_next   = '0;
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
                cap_a_next = '0;
                cap_b_next = '0;
                len_next   = '0;
            end
            else if (item.flush)
            begin
                // nothing pending: drop the flush
            end
            else if (is_colon)
            begin
                len_next   = len_inc;
                cap_a_next = fin_a;
                cap_b_next = fin_b;
                if (idx_ok)
                    idx_next = idx_reg + COL_W'(1);
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                len_next = len_inc;
                unique case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (c == drcf_pkg::CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_dig;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            acc_next   = acc_dig;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cap_a_reg <= '0;
            cap_b_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cap_a_reg <= cap_a_next;
            cap_b_reg <= cap_b_next;
            len_reg   <= len_next;
        end
    end

endmodule

FILE: sv/drcf_out_stage.sv
`timescale 1ns / 1ps
// Result register: holds one line decision until the sink takes it.
// Depends on nothing beyond its parameter.
module drcf_out_stage #(
    parameter int LEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             keep_in,
    input  logic [LEN_W-1:0] len_in,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             keep_out,
    output logic [LEN_W-1:0] len_out
);

    logic             valid_reg;
    logic             keep_reg;
    logic [LEN_W-1:0] len_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            keep_reg <= keep_in;
            len_reg  <= len_in;
        end
    end

    assign out_valid = valid_reg;
    assign keep_out  = keep_reg;
    assign len_out   = len_reg;

endmodule

FILE: sv/delimited_record_column_filter.sv
`timescale 1ns / 1ps
// A result is loaded into the result register when the held request that ends its line advances.
// Throughput: one byte request per cycle; the input register stalls only when a finished
// line meets a result still waiting in the result register.
// Reset (rst_n low, asynchronous): clears the parser, line state and both valid flags and
// loads column_a = 1, column_b = 2, compare_op = greater-than.
module delimited_record_column_filter #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_LINE    = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    drcf_in_if.sink    item,
    drcf_out_if.source result,
    drcf_cfg_if.sink   cfg
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    // Configuration registers; writes are only expected while the block is idle
    drcf_pkg::cfg_t   cfg_reg;

    drcf_pkg::item_t  in_item;
    drcf_pkg::item_t  held_item;
    logic             held_valid;
    logic             advance;
    logic             emit;
    logic             keep_line;
    logic [LEN_W-1:0] line_length;
    logic             out_free;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_a   <= drcf_pkg::COLREG_W'(1);
            cfg_reg.column_b   <= drcf_pkg::COLREG_W'(2);
            cfg_reg.compare_op <= drcf_pkg::OP_GT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                drcf_pkg::REG_COLUMN_A:   cfg_reg.column_a   <= cfg.data;
                drcf_pkg::REG_COLUMN_B:   cfg_reg.column_b   <= cfg.data;
                drcf_pkg::REG_COMPARE_OP: cfg_reg.compare_op <= cfg.data[drcf_pkg::OP_W-1:0];
                default:
                begin
                    // index beyond the register list: drop the write
                end
            endcase
        end
    end

    assign in_item.data_byte = item.data_byte;
    assign in_item.flush     = item.flush;

    // Advance the held request unless it ends a line while the result slot is busy
    assign advance = held_valid && (!emit || out_free);

    drcf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_ready   (item.ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Parse the held byte, capture columns, decide the line in the same cycle
    drcf_line_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINE    (MAX_LINE)
    ) u_line_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (held_item),
        .cfg         (cfg_reg),
        .emit        (emit),
        .keep_line   (keep_line),
        .line_length (line_length)
    );

    // Hold the decision until the sink takes it
    drcf_out_stage #(
        .LEN_W (LEN_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .keep_in   (keep_line),
        .len_in    (line_length),
        .free      (out_free),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .keep_out  (result.keep_line),
        .len_out   (result.line_length)
    );

endmodule

FILE: sv/drcf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the delimited record column filter, bound to the top level.
// Depends on the top level's ports only.
module drcf_checker #(
    parameter int MAX_LINE = 4096,
    parameter int LEN_W    = 13
) (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_keep,
    input logic [LEN_W-1:0] res_len,
    input logic             cfg_ready
);

    // A stalled result keeps its valid and payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_keep) && $stable(res_len))
        else $error("result changed while stalled");

    // Every finished line has at least one byte and never exceeds the saturation bound
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_len != '0) && (res_len <= LEN_W'(MAX_LINE)))
        else $error("line length out of range");

    // Reset clears the result channel
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // Register writes are always taken
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind delimited_record_column_filter drcf_checker #(
    .MAX_LINE (MAX_LINE),
    .LEN_W    (LEN_W)
) u_drcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_keep  (result.keep_line),
    .res_len   (result.line_length),
    .cfg_ready (cfg.ready)
);
